[src/velocity_key_scanner_macros.svh]
// Assertion macros shared by the velocity key scanner RTL.
`ifndef VELOCITY_KEY_SCANNER_MACROS_SVH
`define VELOCITY_KEY_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VKS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("velocity_key_scanner: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("velocity_key_scanner: next-cycle check failed");

`endif

[src/vks_pkg.sv]
// Types, constants and code tables for the velocity key scanner.
package vks_pkg;

    // Field widths
    localparam int SCAN_W = 40;
    localparam int TIME_W = 32;
    localparam int CODE_W = 12;
    localparam int NOTE_W = 7;
    localparam int OCT_W  = 2;

    // Keyboard geometry
    localparam int ROW_STRIDE  = 8;
    localparam int ROWS_DEF    = 8;
    localparam int COLUMNS_DEF = 5;

    // Octave codes
    localparam logic [OCT_W-1:0] OCT_DOWN = 2'd0;
    localparam logic [OCT_W-1:0] OCT_MID  = 2'd1;
    localparam logic [OCT_W-1:0] OCT_UP   = 2'd2;
    localparam logic [NOTE_W-1:0] KEYS_PER_OCTAVE = 7'd12;

    // Pitch and velocity scaling
    localparam int PITCH_STEP = 85;
    localparam int CODE_MAX   = 4095;
    localparam int FULL_SCALE = 5000;
    localparam int VEL_LIMIT  = 500;
    localparam int VEL_OFFSET = 502;
    localparam int VEL_FACTOR = 8;
    localparam int VEL_SHIFT  = 3;      // log2 of VEL_FACTOR
    localparam int VEL_IDX_W  = 6;
    localparam int VEL_STEPS  = 64;
    localparam int NOTE_STEPS = 128;
    // First elapsed count whose scaled value reaches the limit
    localparam logic [VEL_IDX_W-1:0] VEL_SAT_IDX = 6'd63;

    typedef logic [CODE_W-1:0] vel_lut_t  [VEL_STEPS];
    typedef logic [CODE_W-1:0] note_lut_t [NOTE_STEPS];

    // One scan as taken from the input channel
    typedef struct packed {
        logic [SCAN_W-1:0] break_bits;
        logic [SCAN_W-1:0] make_bits;
        logic              octave_down;
        logic              octave_up;
        logic [TIME_W-1:0] now_ms;
        logic              env_active;
    } scan_item_t;

    // One result item
    typedef struct packed {
        logic              gate;
        logic [CODE_W-1:0] key_cv;
        logic [CODE_W-1:0] velocity;
        logic              new_note;
        logic              retrigger;
    } note_item_t;

    // Velocity code per elapsed count; the last entry covers the saturated limit
    function automatic vel_lut_t build_vel_lut();
        vel_lut_t lut;
        int       q;
        for (int i = 0; i < VEL_STEPS; i++) begin
            if (i < VEL_STEPS - 1) begin
                q = ((VEL_OFFSET - VEL_FACTOR * i) * CODE_MAX) / VEL_LIMIT;
            end else begin
                q = ((VEL_OFFSET - VEL_LIMIT) * CODE_MAX) / VEL_LIMIT;
            end
            if (q > CODE_MAX) begin
                q = CODE_MAX;
            end
            lut[i] = CODE_W'(q);
        end
        return lut;
    endfunction

    // Pitch code per note number, where pitch = 85 * note number
    function automatic note_lut_t build_note_lut();
        note_lut_t lut;
        int        q;
        for (int i = 0; i < NOTE_STEPS; i++) begin
            q = (PITCH_STEP * i * CODE_MAX) / FULL_SCALE;
            if (q > CODE_MAX) begin
                q = CODE_MAX;
            end
            lut[i] = CODE_W'(q);
        end
        return lut;
    endfunction

    // Bits of the scan word that belong to scanned rows and columns
    function automatic logic [SCAN_W-1:0] scan_mask(int rows, int cols);
        logic [SCAN_W-1:0] m;
        for (int s = 0; s < SCAN_W; s++) begin
            m[s] = ((s % ROW_STRIDE) < rows) && ((s / ROW_STRIDE) < cols);
        end
        return m;
    endfunction

    localparam vel_lut_t  VEL_LUT  = build_vel_lut();
    localparam note_lut_t NOTE_LUT = build_note_lut();

endpackage

[src/vks_press_mem.sv]
// Press-time memory: one write port, one registered read port, per-entry valid bits.
module vks_press_mem
    import vks_pkg::*;
#(
    parameter int DEPTH = 40,
    parameter int IDX_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem_array [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    // Write and read the storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    // Track written entries; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[src/vks_code_lut.sv]
// Pitch and velocity code lookup from note number and elapsed press time.
module vks_code_lut
    import vks_pkg::*;
(
    input  logic [NOTE_W-1:0] note_num,
    input  logic [TIME_W-1:0] elapsed,
    output logic [CODE_W-1:0] key_cv,
    output logic [CODE_W-1:0] velocity
);

    logic                 vel_sat;
    logic [VEL_IDX_W-1:0] vel_idx;

    // Saturate once eight times the elapsed count, mod 2^32, reaches the limit
    assign vel_sat = (elapsed[TIME_W-VEL_SHIFT-1:VEL_IDX_W] != '0)
                  || (elapsed[VEL_IDX_W-1:0] == VEL_SAT_IDX);
    assign vel_idx = vel_sat ? VEL_SAT_IDX : elapsed[VEL_IDX_W-1:0];

    assign velocity = VEL_LUT[vel_idx];
    assign key_cv   = NOTE_LUT[note_num];

endmodule

[src/vks_scan_ctrl.sv]
// Scan sequencer: walks the press-time memory, picks the note, posts one result per scan.
module vks_scan_ctrl
    import vks_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int DEPTH   = 40,
    parameter int IDX_W   = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    output logic       scan_ready,
    input  scan_item_t scan,
    output logic       res_valid,
    input  logic       res_ready,
    output note_item_t res
);

    localparam logic [SCAN_W-1:0] FULL_MASK = scan_mask(ROWS, COLUMNS);
    localparam logic [DEPTH-1:0]  KEY_MASK  = FULL_MASK[DEPTH-1:0];
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [DEPTH-1:0]  brk_reg;
    logic [DEPTH-1:0]  mk_reg;
    logic [DEPTH-1:0]  prev_reg;
    logic [OCT_W-1:0]  oct_reg;
    logic [TIME_W-1:0] now_reg;
    logic              env_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  sel_reg;
    logic [NOTE_W-1:0] last_note_reg;
    logic [CODE_W-1:0] pitch_code_reg;
    logic [CODE_W-1:0] vel_code_reg;
    logic              gate_reg;
    logic              new_note_reg;
    logic              retrig_reg;

    logic              rising;
    logic [NOTE_W-1:0] oct_offset;
    logic [NOTE_W-1:0] note_num;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              rd_en;
    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] elapsed;
    logic [CODE_W-1:0] key_cv;
    logic [CODE_W-1:0] velocity;

    // Break contact that closed since the last scan
    assign rising = brk_reg[cnt_reg] & ~prev_reg[cnt_reg];

    // Note number: key (1-based) plus twelve per octave
    always_comb
    begin
        unique case (oct_reg)
            OCT_DOWN: oct_offset = '0;
            OCT_MID:  oct_offset = KEYS_PER_OCTAVE;
            OCT_UP:   oct_offset = KEYS_PER_OCTAVE + KEYS_PER_OCTAVE;
            default:  oct_offset = '0;
        endcase
    end
    assign note_num = NOTE_W'(sel_reg) + NOTE_W'(1) + oct_offset;

    // Memory access: store press times while walking, clear the played key after use
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = now_reg;
        if (state_reg == ST_WALK)
        begin
            wr_en = rising;
        end
        else if (state_reg == ST_CALC)
        begin
            wr_en   = 1'b1;
            wr_addr = sel_reg;
            wr_data = '0;
        end
    end
    assign rd_en = (state_reg == ST_CHECK) && found_reg && (note_num != last_note_reg);

    vks_press_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_press_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (sel_reg),
        .rd_data (rd_data)
    );

    assign elapsed = now_reg - rd_data;

    vks_code_lut u_code_lut (
        .note_num (note_num),
        .elapsed  (elapsed),
        .key_cv   (key_cv),
        .velocity (velocity)
    );

    // Sequence one scan
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (scan_valid) state_next = ST_WALK;
            ST_WALK:  if (cnt_reg == LAST_IDX) state_next = ST_CHECK;
            ST_CHECK: state_next = rd_en ? ST_CALC : ST_POST;
            ST_CALC:  state_next = ST_POST;
            ST_POST:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Hold scan data, walk keys, update the held note
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            brk_reg        <= '0;
            mk_reg         <= '0;
            prev_reg       <= '0;
            oct_reg        <= OCT_MID;
            now_reg        <= '0;
            env_reg        <= 1'b0;
            found_reg      <= 1'b0;
            sel_reg        <= '0;
            last_note_reg  <= '0;
            pitch_code_reg <= '0;
            vel_code_reg   <= '0;
            gate_reg       <= 1'b0;
            new_note_reg   <= 1'b0;
            retrig_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (scan_valid)
                    begin
                        brk_reg   <= scan.break_bits[DEPTH-1:0] & KEY_MASK;
                        mk_reg    <= scan.make_bits[DEPTH-1:0] & KEY_MASK;
                        oct_reg   <= scan.octave_down ? OCT_DOWN
                                   : (scan.octave_up ? OCT_UP : OCT_MID);
                        now_reg   <= scan.now_ms;
                        env_reg   <= scan.env_active;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                end
                ST_WALK:
                begin
                    if (!found_reg && mk_reg[cnt_reg])
                    begin
                        found_reg <= 1'b1;
                        sel_reg   <= cnt_reg;
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        prev_reg <= brk_reg;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_CHECK:
                begin
                    gate_reg     <= found_reg;
                    new_note_reg <= 1'b0;
                    retrig_reg   <= 1'b0;
                end
                ST_CALC:
                begin
                    last_note_reg  <= note_num;
                    pitch_code_reg <= key_cv;
                    vel_code_reg   <= velocity;
                    new_note_reg   <= 1'b1;
                    retrig_reg     <= env_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign scan_ready    = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_POST);
    assign res.gate      = gate_reg;
    assign res.key_cv    = pitch_code_reg;
    assign res.velocity  = vel_code_reg;
    assign res.new_note  = new_note_reg;
    assign res.retrigger = retrig_reg;

endmodule

[src/velocity_key_scanner.sv]
// Velocity key scanner top level: stream ports, output register, checks.
//
// Usage: each item on the s_axis channel is one full scan of a dual-contact
// keyboard (break and make contacts, octave switches, millisecond time and an
// envelope flag). For each scan exactly one item leaves on the m_axis channel
// with the gate, the held pitch and velocity codes and the note flags.
// Flow: after acceptance a scan walks the press-time memory, one key entry per
// cycle through its single write port, then the note is checked, new codes
// are computed when a new note is posted, and the result is posted to the
// output register. One scan is worked on at a time; s_axis_tready is high
// only between scans, so a new scan is not taken before the last one has
// been posted.
// Reset: all press times read as zero (per-entry valid bits, no clearing
// pass), previous contacts, last note and held codes are cleared.
// Stall: the output register holds its item while m_axis_tready is low; the
// next scan is still accepted and worked on, and waits for the register.
module velocity_key_scanner
    import vks_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // break_bits[39:0], make_bits[79:40], octave_down[80], octave_up[81],
    // now_ms[113:82], env_active[114], zero[119:115]
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // gate[0], key_cv[12:1], velocity[24:13], new_note[25], retrigger[26],
    // zero[31:27]
    output logic [31:0]  m_axis_tdata
);

`include "velocity_key_scanner_macros.svh"

    localparam int DEPTH = (COLUMNS - 1) * ROW_STRIDE + ROWS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    scan_item_t scan;
    note_item_t res;
    note_item_t out_reg;
    logic       res_valid;
    logic       res_ready;
    logic       out_valid_reg;

    // Unpack the scan item
    assign scan.break_bits  = s_axis_tdata[39:0];
    assign scan.make_bits   = s_axis_tdata[79:40];
    assign scan.octave_down = s_axis_tdata[80];
    assign scan.octave_up   = s_axis_tdata[81];
    assign scan.now_ms      = s_axis_tdata[113:82];
    assign scan.env_active  = s_axis_tdata[114];

    vks_scan_ctrl #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .DEPTH   (DEPTH),
        .IDX_W   (IDX_W)
    ) u_scan_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (s_axis_tvalid),
        .scan_ready (s_axis_tready),
        .scan       (scan),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Load the output register when it is empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.retrigger, out_reg.new_note,
                            out_reg.velocity, out_reg.key_cv, out_reg.gate};

    // Checks
    `VKS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `VKS_ASSERT_NEXT(a_result_loaded, clk, rst_n, res_valid && res_ready, m_axis_tvalid)
    `VKS_ASSERT_NOW(a_note_needs_gate, clk, rst_n, m_axis_tvalid && !m_axis_tdata[0], !m_axis_tdata[25])
    `VKS_ASSERT_NOW(a_retrig_needs_note, clk, rst_n, m_axis_tvalid && !m_axis_tdata[25], !m_axis_tdata[26])

endmodule

[verif/velocity_key_scanner_tb.sv]
// Self-checking stream testbench for the velocity key scanner.
module velocity_key_scanner_tb;
    import vks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int IDLE_PCT     = 32;
    localparam int RANDOM_SCANS = 1150;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 850;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int OCTAVE_STEP  = PITCH_STEP * int'(KEYS_PER_OCTAVE);

    // One keyboard scan as offered on the input channel
    typedef struct {
        logic [SCAN_W-1:0] break_bits;
        logic [SCAN_W-1:0] make_bits;
        logic              octave_down;
        logic              octave_up;
        logic [TIME_W-1:0] now_ms;
        logic              env_active;
    } scan_t;

    // One note update as returned on the output channel
    typedef struct {
        logic              gate;
        logic [CODE_W-1:0] key_cv;
        logic [CODE_W-1:0] velocity;
        logic              new_note;
        logic              retrigger;
    } note_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;

    scan_t pending_scans[$];
    note_t notes_due[$];
    scan_t on_bus;

    int          scans_queued = 0;
    int          scans_sent = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    logic        hold_done = 1'b0;
    logic        quiet_span;
    logic [TIME_W-1:0] stim_ms = '0;

    // Shadow keyboard state
    logic [SCAN_W-1:0] break_held = '0;
    logic [TIME_W-1:0] press_ms[SCAN_W];
    logic [12:0]       last_pitch = '0;
    logic [CODE_W-1:0] held_key_cv = '0;
    logic [CODE_W-1:0] held_velocity = '0;

    initial
    begin
        for (int s = 0; s < SCAN_W; s++)
        begin
            press_ms[s] = '0;
        end
    end

    velocity_key_scanner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    assign quiet_span = (scans_sent >= QUIET_FIRST) && (scans_sent < QUIET_LAST);

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Advance the shadow keyboard by one scan and return the note it produces
    function automatic note_t scan_keyboard(input scan_t sc);
        note_t             res;
        logic [OCT_W-1:0]  octave;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] scaled;
        logic              found;
        int                sel;
        int                pitch;
        int                code;
        octave = sc.octave_down ? OCT_DOWN : (sc.octave_up ? OCT_UP : OCT_MID);
        found = 1'b0;
        sel = 0;
        res.new_note = 1'b0;
        res.retrigger = 1'b0;
        // latch press times on rising break contacts, pick the lowest made key
        for (int s = 0; s < SCAN_W; s++)
        begin
            if (sc.break_bits[s] && !break_held[s])
            begin
                press_ms[s] = sc.now_ms;
            end
            if (!found && sc.make_bits[s])
            begin
                found = 1'b1;
                sel = s;
            end
        end
        break_held = sc.break_bits;
        if (found)
        begin
            pitch = PITCH_STEP * (sel + 1) + OCTAVE_STEP * int'(octave);
            if (pitch != int'(last_pitch))
            begin
                code = (pitch * CODE_MAX) / FULL_SCALE;
                held_key_cv = CODE_W'((code > CODE_MAX) ? CODE_MAX : code);
                // elapsed and its scaled value both wrap at 32 bits
                elapsed = sc.now_ms - press_ms[sel];
                scaled = elapsed * VEL_FACTOR;
                if (scaled > VEL_LIMIT)
                begin
                    scaled = VEL_LIMIT;
                end
                code = ((VEL_OFFSET - int'(scaled)) * CODE_MAX) / VEL_LIMIT;
                held_velocity = CODE_W'((code > CODE_MAX) ? CODE_MAX : code);
                last_pitch = 13'(pitch);
                press_ms[sel] = '0;
                res.new_note = 1'b1;
                res.retrigger = sc.env_active;
            end
        end
        res.gate = found;
        res.key_cv = held_key_cv;
        res.velocity = held_velocity;
        return res;
    endfunction

    task automatic queue_scan(input logic [SCAN_W-1:0] brk, input logic [SCAN_W-1:0] mk,
                              input logic down, input logic up, input logic env,
                              input logic [TIME_W-1:0] gap);
        scan_t sc;
        sc.break_bits = brk;
        sc.make_bits = mk;
        sc.octave_down = down;
        sc.octave_up = up;
        sc.now_ms = stim_ms;
        sc.env_active = env;
        pending_scans.push_back(sc);
        scans_queued++;
        stim_ms = stim_ms + gap;
    endtask

    function automatic logic [SCAN_W-1:0] rand_scan_word();
        return SCAN_W'({$urandom(), $urandom()});
    endfunction

    // Play one keystroke: break closes, make follows after the travel time, then release
    task automatic strike(input int key_idx, input logic [TIME_W-1:0] travel);
        logic [SCAN_W-1:0] key_bit;
        logic [SCAN_W-1:0] chord_mk;
        logic              down;
        logic              up;
        logic              env;
        int                n;
        key_bit = SCAN_W'(1) << key_idx;
        chord_mk = '0;
        if ($urandom_range(99) < 25)
        begin
            chord_mk = rand_scan_word() & rand_scan_word() & rand_scan_word();
        end
        down = ($urandom_range(3) == 0);
        up = ($urandom_range(1) == 0);
        env = 1'($urandom_range(1));
        n = $urandom_range(2);
        queue_scan(chord_mk | key_bit, chord_mk, down, up, env, '0);
        repeat (n) queue_scan(chord_mk | key_bit, chord_mk, down, up, env, '0);
        stim_ms = stim_ms + travel;
        n = $urandom_range(1, 3);
        repeat (n) queue_scan(chord_mk | key_bit, chord_mk | key_bit, down, up, env, 1);
        queue_scan(chord_mk | key_bit, chord_mk, down, up, env, 1);
        queue_scan(chord_mk, chord_mk, down, up, env, $urandom_range(1, 20));
    endtask

    // Stimulus and end of run
    initial
    begin
        logic [TIME_W-1:0] travel;
        int                r;
        int                n;

        // no key held
        queue_scan('0, '0, 1'b0, 1'b0, 1'b0, 0);
        // make without break, octave down, envelope running
        queue_scan('0, SCAN_W'(1), 1'b1, 1'b0, 1'b1, 0);
        // same pitch held
        queue_scan('0, SCAN_W'(1), 1'b1, 1'b1, 1'b1, 3);
        // every contact closed, octave up
        queue_scan('1, '1, 1'b0, 1'b1, 1'b0, 5);
        // top key, octave up: pitch code saturates
        queue_scan('1, SCAN_W'(1) << 39, 1'b0, 1'b1, 1'b1, 1);
        queue_scan('1, SCAN_W'(1) << 34, 1'b0, 1'b1, 1'b0, 1);
        queue_scan('1, SCAN_W'(1) << 33, 1'b0, 1'b1, 1'b0, 1);
        // release everything, codes hold
        queue_scan('0, '0, 1'b0, 1'b0, 1'b1, 1);
        // press across the time wrap
        stim_ms = 32'hFFFF_FFF0;
        queue_scan(SCAN_W'(1) << 5, '0, 1'b0, 1'b0, 1'b0, 26);
        queue_scan(SCAN_W'(1) << 5, SCAN_W'(1) << 5, 1'b0, 1'b0, 1'b1, 1);
        // scaled velocity just below and at its limit
        queue_scan(SCAN_W'(3) << 6, '0, 1'b0, 1'b0, 1'b0, 62);
        queue_scan(SCAN_W'(3) << 6, SCAN_W'(1) << 6, 1'b0, 1'b0, 1'b0, 1);
        queue_scan(SCAN_W'(1) << 7, SCAN_W'(1) << 7, 1'b0, 1'b0, 1'b0, 1);
        // elapsed times eight wraps to zero
        queue_scan(SCAN_W'(1) << 8, '0, 1'b1, 1'b0, 1'b0, 32'h2000_0000);
        queue_scan(SCAN_W'(1) << 8, SCAN_W'(1) << 8, 1'b1, 1'b0, 1'b1, 1);
        // largest time value, octave mid
        stim_ms = 32'hFFFF_FFFF;
        queue_scan(SCAN_W'(1) << 20, SCAN_W'(1) << 21, 1'b0, 1'b0, 1'b1, 1);
        queue_scan('0, SCAN_W'(1) << 21, 1'b0, 1'b0, 1'b0, 1);
        queue_scan('0, '0, 1'b0, 1'b0, 1'b0, 1);

        // random part: mostly keystrokes, some contact noise
        n = scans_queued + RANDOM_SCANS;
        while (scans_queued < n)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                stim_ms = $urandom();
            end
            else if (r < 5)
            begin
                stim_ms = 32'hFFFF_FFFF - $urandom_range(40);
            end
            if ($urandom_range(99) < 80)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    travel = $urandom_range(70);
                end
                else if (r < 85)
                begin
                    travel = $urandom_range(71, 700);
                end
                else if (r < 93)
                begin
                    travel = $urandom();
                end
                else
                begin
                    travel = TIME_W'({$urandom_range(1, 7), 29'd0}) + $urandom_range(70);
                end
                strike($urandom_range(SCAN_W - 1), travel);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_scan(($urandom_range(1) == 0) ? rand_scan_word()
                                                       : rand_scan_word() & rand_scan_word(),
                               ($urandom_range(3) == 0) ? '0 : rand_scan_word() & rand_scan_word(),
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), $urandom_range(50));
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every scan to go in and every note to come back
        while (scans_sent != scans_queued || notes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (notes_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected notes never arrived", notes_due.size()));
        end
        if (error_count == 0)
        begin
            $display("velocity_key_scanner_tb passed");
        end
        else
        begin
            $display("velocity_key_scanner_tb failed");
        end
        $finish;
    end

    // Driver: offer queued scans, predict each accepted one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                notes_due.push_back(scan_keyboard(on_bus));
                scans_sent <= scans_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_scans.size() != 0
                    && (quiet_span || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_bus = pending_scans.pop_front();
                    s_axis_tdata <= {5'd0, on_bus.env_active, on_bus.now_ms, on_bus.octave_up,
                                     on_bus.octave_down, on_bus.make_bits, on_bus.break_bits};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the output once for a long stretch so the input backs up
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_done && scans_sent == HOLD_AT)
        begin
            hold_cycles <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Monitor: compare each accepted note with the oldest expectation
    always @(posedge clk)
    begin
        note_t got;
        note_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.gate = m_axis_tdata[0];
                got.key_cv = m_axis_tdata[12:1];
                got.velocity = m_axis_tdata[24:13];
                got.new_note = m_axis_tdata[25];
                got.retrigger = m_axis_tdata[26];
                if (notes_due.size() == 0)
                begin
                    report_mismatch("note item with no scan pending");
                end
                else
                begin
                    want = notes_due.pop_front();
                    if (got.gate !== want.gate)
                    begin
                        report_mismatch($sformatf("gate got %0d want %0d", got.gate, want.gate));
                    end
                    if (got.key_cv !== want.key_cv)
                    begin
                        report_mismatch($sformatf("key_cv got %0d want %0d",
                                                  got.key_cv, want.key_cv));
                    end
                    if (got.velocity !== want.velocity)
                    begin
                        report_mismatch($sformatf("velocity got %0d want %0d",
                                                  got.velocity, want.velocity));
                    end
                    if (got.new_note !== want.new_note)
                    begin
                        report_mismatch($sformatf("new_note got %0d want %0d",
                                                  got.new_note, want.new_note));
                    end
                    if (got.retrigger !== want.retrigger)
                    begin
                        report_mismatch($sformatf("retrigger got %0d want %0d",
                                                  got.retrigger, want.retrigger));
                    end
                end
            end
            m_axis_tready <= (hold_cycles == 0) && (quiet_span || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("velocity_key_scanner_tb failed");
            $finish;
        end
    end

endmodule
